@@ rtl/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg - shared types and constants of the LED pattern generator
// Command and mode codes, register indexes, controller types and the
// breathing sine ROM, which is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

	// action codes of an input word
	typedef enum logic [1:0] {
		ACT_TICK      = 2'd0,
		ACT_SET_MODE  = 2'd1,
		ACT_SET_LEVEL = 2'd2
	} action_e;

	// LED modes
	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_ON      = 3'd1,
		MODE_SLOW    = 3'd2,
		MODE_FAST    = 3'd3,
		MODE_BREATHE = 3'd4,
		MODE_FLASH   = 3'd5
	} mode_e;

	// configuration register indexes
	localparam logic [2:0] REG_SLOW_PERIOD    = 3'd0;
	localparam logic [2:0] REG_FAST_PERIOD    = 3'd1;
	localparam logic [2:0] REG_BREATHE_PERIOD = 3'd2;
	localparam logic [2:0] REG_FLASH_ON       = 3'd3;
	localparam logic [2:0] REG_BREATHE_MIN    = 3'd4;
	localparam logic [2:0] REG_BREATHE_MAX    = 3'd5;
	localparam logic [2:0] REG_PWM_PRESENT    = 3'd6;
	localparam logic [2:0] REG_PIN_POLARITY   = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [6:0] LEVEL_MAX     = 7'd100;
	localparam logic [6:0] LEVEL_RESET   = 7'd100;
	localparam logic [8:0] LIT_THRESHOLD = 9'd50;
	localparam logic [9:0] PWM_SCALE     = 10'd10;

	// sine table geometry
	localparam int SINE_STEPS = 256;
	localparam int SINE_BITS  = $clog2(SINE_STEPS);
	localparam int SINE_W     = 16;

	// phase divider: (since_start * SINE_STEPS) / period, radix 2, two bits a cycle
	localparam int PERIOD_W            = 16;
	localparam int DIV_W               = 32 + SINE_BITS;
	localparam int DIV_STEPS_PER_CYCLE = 2;
	localparam int DIV_CYCLES          = DIV_W / DIV_STEPS_PER_CYCLE;
	localparam int DIV_CNT_W           = $clog2(DIV_CYCLES);

	// span * sine product
	localparam int PROD_W = 7 + SINE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_DIVIDE,
		ST_MULT,
		ST_SCALE,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;   // latch the input word
		logic exec;      // apply tick / set mode / set level
		logic div_load;  // start the phase divider
		logic div_step;  // one divider step
		logic mult;      // span * sine
		logic scale;     // scale to percent, update level and, without PWM, lit
		logic out_load;  // load the result register
	} lpg_cmd_t;

	typedef struct packed {
		logic breathe;   // latched word is a tick in breathe mode
	} lpg_status_t;

	// sine ROM, Q30 Taylor series with quarter-wave fold
	typedef logic [SINE_STEPS-1:0][SINE_W-1:0] sine_rom_t;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] a;
		logic [63:0] n;
		logic [63:0] num;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] u;
		logic [63:0] full;
		logic        neg;
		n = 64'(SINE_STEPS);
		for (int k = 0; k < SINE_STEPS; k++) begin
			a = 64'(4 * k);
			if (a <= n) begin
				num = a;
				neg = 1'b0;
			end else if (a <= 2 * n) begin
				num = 2 * n - a;
				neg = 1'b0;
			end else if (a <= 3 * n) begin
				num = a - 2 * n;
				neg = 1'b1;
			end else begin
				num = 4 * n - a;
				neg = 1'b1;
			end
			f    = num << (30 - SINE_BITS);
			x    = (f * HALF_PI_Q30) >> 30;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int i = 0; i < 5; i++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[i];
				if ((i % 2) == 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum > Q30_ONE) begin
				sum = Q30_ONE;
			end
			u      = neg ? (Q30_ONE - sum) : (Q30_ONE + sum);
			full   = (u * 64'd65535 + Q30_ONE) >> 31;
			rom[k] = full[SINE_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

@@ rtl/lpg_div.sv @@
// ----------------------------------------------------------------------------
// lpg_div - iterative restoring divider for the breathing phase
// Two quotient bits a cycle; the low quotient bits give the sine index.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_div
	import lpg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic                 step,
	input  wire logic [DIV_W-1:0]     dividend,
	input  wire logic [PERIOD_W-1:0]  divisor,
	output logic      [SINE_BITS-1:0] quotient_lo
);

	logic [PERIOD_W-1:0] rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [PERIOD_W-1:0] rem_d;
	logic [DIV_W-1:0]    quo_d;
	logic [PERIOD_W:0]   trial;
	logic                fits;

	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		fits  = 1'b0;
		for (int i = 0; i < DIV_STEPS_PER_CYCLE; i++) begin
			trial = {rem_d, quo_d[DIV_W-1]};
			fits  = trial >= {1'b0, divisor};
			rem_d = fits ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
			quo_d = {quo_d[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign quotient_lo = quo_q[SINE_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/lpg_datapath.sv @@
// ----------------------------------------------------------------------------
// lpg_datapath - pattern state, configuration and result registers
// Applies commands and ticks, runs the breathing scale, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_datapath
	import lpg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [1:0]            action,
	input  wire logic [2:0]            mode,
	input  wire logic [15:0]           flash_times,
	input  wire logic [7:0]            level_request,
	input  wire lpg_cmd_t              cmd,
	output lpg_status_t                status,
	output logic                       pin_level,
	output logic [6:0]                 brightness_pct,
	output logic [9:0]                 pwm_compare,
	output logic [2:0]                 mode_now,
	output logic                       pattern_running
);

	// configuration
	logic [15:0] slow_period_q;
	logic [15:0] fast_period_q;
	logic [15:0] breathe_period_q;
	logic [14:0] flash_on_q;
	logic [6:0]  breathe_min_q;
	logic [6:0]  breathe_max_q;
	logic        pwm_present_q;
	logic        polarity_q;

	// pattern state
	mode_e       cur_mode_q;
	logic        running_q;
	logic        lit_q;
	logic [31:0] since_start_q;
	logic [15:0] since_toggle_q;
	logic [15:0] flashes_left_q;
	logic [6:0]  level_q;

	// latched input word
	logic [1:0]  action_q;
	logic [2:0]  mode_q;
	logic [15:0] flash_times_q;
	logic [7:0]  level_request_q;

	logic [PROD_W-1:0] prod_q;

	// result register
	logic        pin_q;
	logic [6:0]  bright_q;
	logic [9:0]  pwm_q;
	logic [2:0]  mode_now_q;
	logic        running_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_period_q    <= 16'd1000;
			fast_period_q    <= 16'd250;
			breathe_period_q <= 16'd2000;
			flash_on_q       <= 15'd100;
			breathe_min_q    <= 7'd10;
			breathe_max_q    <= 7'd100;
			pwm_present_q    <= 1'b0;
			polarity_q       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOW_PERIOD:    slow_period_q    <= cfg_data;
				REG_FAST_PERIOD:    fast_period_q    <= cfg_data;
				REG_BREATHE_PERIOD: breathe_period_q <= cfg_data;
				REG_FLASH_ON:       flash_on_q       <= cfg_data[14:0];
				REG_BREATHE_MIN:    breathe_min_q    <= cfg_data[6:0];
				REG_BREATHE_MAX:    breathe_max_q    <= cfg_data[6:0];
				REG_PWM_PRESENT:    pwm_present_q    <= cfg_data[0];
				REG_PIN_POLARITY:   polarity_q       <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q        <= action;
			mode_q          <= mode;
			flash_times_q   <= flash_times;
			level_request_q <= level_request;
		end
	end

	// ---- command / tick update ----
	logic [31:0] ss_inc;
	logic [15:0] st_inc;
	logic [14:0] half_period;
	mode_e       mode_d;
	logic        running_d;
	logic        lit_d;
	logic [31:0] since_start_d;
	logic [15:0] since_toggle_d;
	logic [15:0] flashes_left_d;
	logic [6:0]  level_d;

	assign ss_inc      = since_start_q + 32'd1;
	assign st_inc      = (since_toggle_q == 16'hFFFF) ? since_toggle_q : since_toggle_q + 16'd1;
	assign half_period = (cur_mode_q == MODE_SLOW) ? slow_period_q[15:1] : fast_period_q[15:1];

	always_comb begin
		mode_d         = cur_mode_q;
		running_d      = running_q;
		lit_d          = lit_q;
		since_start_d  = since_start_q;
		since_toggle_d = since_toggle_q;
		flashes_left_d = flashes_left_q;
		level_d        = level_q;
		case (action_q)
			ACT_TICK: begin
				if (running_q) begin
					since_start_d  = ss_inc;
					since_toggle_d = st_inc;
					case (cur_mode_q)
						MODE_SLOW, MODE_FAST: begin
							if (st_inc >= {1'b0, half_period}) begin
								lit_d          = ~lit_q;
								since_toggle_d = '0;
							end
						end
						MODE_FLASH: begin
							if (flashes_left_q != 16'd0) begin
								if (ss_inc < {17'd0, flash_on_q}) begin
									lit_d = 1'b1;
								end else if (ss_inc < {16'd0, flash_on_q, 1'b0}) begin
									lit_d = 1'b0;
								end else begin
									flashes_left_d = flashes_left_q - 16'd1;
									since_start_d  = '0;
									if (flashes_left_q == 16'd1) begin
										running_d = 1'b0;
										mode_d    = MODE_OFF;
										lit_d     = 1'b0;
									end
								end
							end
						end
						default: ;  // breathe finishes in the scale step
					endcase
				end
			end
			ACT_SET_MODE: begin
				if (mode_q <= MODE_FLASH) begin
					mode_d         = mode_e'(mode_q);
					since_start_d  = '0;
					since_toggle_d = '0;
					case (mode_e'(mode_q))
						MODE_OFF: begin
							running_d = 1'b0;
							lit_d     = 1'b0;
						end
						MODE_ON: begin
							running_d = 1'b0;
							lit_d     = 1'b1;
						end
						MODE_FLASH: begin
							running_d      = 1'b1;
							flashes_left_d = flash_times_q;
						end
						default: running_d = 1'b1;
					endcase
				end
			end
			ACT_SET_LEVEL: begin
				level_d = (level_request_q > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_request_q[6:0];
			end
			default: ;
		endcase
	end

	assign status.breathe = (action_q == ACT_TICK) && running_q && (cur_mode_q == MODE_BREATHE);

	// ---- breathing phase and scale ----
	logic [PERIOD_W-1:0]  breathe_div;
	logic [SINE_BITS-1:0] sine_idx;
	logic [6:0]           span;
	logic [6:0]           q_est;
	logic [16:0]          q_rem;
	logic [7:0]           q_fix;
	logic [8:0]           b_raw;
	logic [6:0]           b_sat;

	assign breathe_div = (breathe_period_q == 16'd0) ? 16'd1 : breathe_period_q;
	assign span        = (breathe_max_q >= breathe_min_q) ? breathe_max_q - breathe_min_q : 7'd0;

	lpg_div u_div (
		.clk         (clk),
		.load        (cmd.div_load),
		.step        (cmd.div_step),
		.dividend    ({since_start_q, {SINE_BITS{1'b0}}}),
		.divisor     (breathe_div),
		.quotient_lo (sine_idx)
	);

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_q <= PROD_W'(span) * PROD_W'(SINE_ROM[sine_idx]);
		end
	end

	// x / 65535: x >> 16 is low by at most one
	assign q_est = prod_q[PROD_W-1:16];
	assign q_rem = {1'b0, prod_q[15:0]} + 17'(q_est);
	assign q_fix = (q_rem >= 17'h0FFFF) ? {1'b0, q_est} + 8'd1 : {1'b0, q_est};
	assign b_raw = 9'(breathe_min_q) + 9'(q_fix);
	assign b_sat = (b_raw > 9'(LEVEL_MAX)) ? LEVEL_MAX : b_raw[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q     <= MODE_OFF;
			running_q      <= 1'b0;
			lit_q          <= 1'b0;
			since_start_q  <= '0;
			since_toggle_q <= '0;
			flashes_left_q <= '0;
			level_q        <= LEVEL_RESET;
		end else if (cmd.exec) begin
			cur_mode_q     <= mode_d;
			running_q      <= running_d;
			lit_q          <= lit_d;
			since_start_q  <= since_start_d;
			since_toggle_q <= since_toggle_d;
			flashes_left_q <= flashes_left_d;
			level_q        <= level_d;
		end else if (cmd.scale) begin
			level_q <= b_sat;
			if (!pwm_present_q) begin
				lit_q <= (b_raw > LIT_THRESHOLD);
			end
		end
	end

	// ---- result register ----
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pin_q         <= ~(lit_q ^ polarity_q);
			bright_q      <= level_q;
			pwm_q         <= pwm_present_q ? 10'(10'(level_q) * PWM_SCALE) : 10'd0;
			mode_now_q    <= cur_mode_q;
			running_out_q <= running_q;
		end
	end

	assign pin_level       = pin_q;
	assign brightness_pct  = bright_q;
	assign pwm_compare     = pwm_q;
	assign mode_now        = mode_now_q;
	assign pattern_running = running_out_q;

endmodule

`default_nettype wire

@@ rtl/lpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpg_ctrl - sequencing controller of the LED pattern generator
// Walks each word through execute, breathing divide/scale and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_ctrl
	import lpg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire lpg_status_t status,
	output lpg_cmd_t         cmd
);

	ctrl_state_t          state_q;
	ctrl_state_t          state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_EXEC;
			ST_EXEC:   state_d = status.breathe ? ST_LOAD : ST_DONE;
			ST_LOAD:   state_d = ST_DIVIDE;
			ST_DIVIDE: if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) state_d = ST_MULT;
			ST_MULT:   state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC:   cmd.exec     = 1'b1;
			ST_LOAD:   cmd.div_load = 1'b1;
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_MULT:   cmd.mult     = 1'b1;
			ST_SCALE:  cmd.scale    = 1'b1;
			ST_DONE:   cmd.out_load = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/led_pattern_generator_unit.sv @@
// ----------------------------------------------------------------------------
// led_pattern_generator_unit - one-LED blink / breathe / flash pattern engine
// Sequence: commands and ticks outside breathe mode go through capture,
//   execute and result load; a breathe tick adds the phase divider at two
//   quotient bits a cycle, then multiply and scale, before the result load.
// Flow: one word in flight; the result load waits for a free result register.
// Reset: arst_n resets pattern state, loads default config, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_generator_unit
	import lpg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input word: tick or command
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            action,
	input  wire logic [2:0]            mode,
	input  wire logic [15:0]           flash_times,
	input  wire logic [7:0]            level_request,
	// result word: LED state after the update
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       pin_level,
	output logic [6:0]                 brightness_pct,
	output logic [9:0]                 pwm_compare,
	output logic [2:0]                 mode_now,
	output logic                       pattern_running
);

	// The controller only sequences; all pattern state lives in the datapath.
	// A new word is taken as soon as the previous result sits in the result
	// register, even while that result still waits for out_ready.
	lpg_cmd_t    cmd;
	lpg_status_t status;

	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Breathe ticks: phase index = (since_start * SINE_STEPS) / period through
	// the iterative divider, then span * sine, then /65535 with one correction.
	lpg_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (action),
		.mode            (mode),
		.flash_times     (flash_times),
		.level_request   (level_request),
		.cmd             (cmd),
		.status          (status),
		.pin_level       (pin_level),
		.brightness_pct  (brightness_pct),
		.pwm_compare     (pwm_compare),
		.mode_now        (mode_now),
		.pattern_running (pattern_running)
	);

	// ---- assertions ----

	// one word in flight: no back-to-back accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in flight");

	// level is always clamped or saturated
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> brightness_pct <= LEVEL_MAX)
		else $error("brightness above 100");

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pwm_compare <= 10'd1000)
		else $error("pwm compare above 1000");

	// a running pattern is never off or steady on
	a_running_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pattern_running |-> mode_now != MODE_OFF && mode_now != MODE_ON)
		else $error("pattern running in a static mode");

endmodule

`default_nettype wire

@@ dv/tb_led_pattern_generator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_led_pattern_generator_unit - self-checking bench for the LED pattern unit
// Sends tick, set-mode and set-brightness words through the valid/ready input
// and rebuilds the LED state after each word in a cycle-free predictor. The
// predictor has its own sine table and register copies. Each result word is
// compared field by field against the oldest predicted state. The run covers
// a directed opening and randomized phases under several register settings,
// with random idling on both handshakes in all but one calm phase.
// ----------------------------------------------------------------------------

module tb_led_pattern_generator_unit
	import lpg_pkg::*;
;

	// codes the block must ignore
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam logic [2:0] MODE_RSVD_6 = 3'd6;
	localparam logic [2:0] MODE_RSVD_7 = 3'd7;

	localparam int unsigned PCT_FULL      = 100;
	localparam int unsigned LIT_ABOVE_PCT = 50;
	localparam int unsigned PWM_PER_PCT   = 10;

	// slowest word is a breathe tick; allow for that plus slack
	localparam int SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 118;

	// LED state as seen on the result port
	typedef struct packed {
		logic       pin;
		logic [6:0] bright;
		logic [9:0] pwm;
		logic [2:0] mode;
		logic       run;
	} led_view_t;

	// Pattern predictor plus the queue of LED states still to come out.
	class led_state_board;
		// register copies
		bit [15:0] slow_period, fast_period, breathe_period;
		bit [14:0] flash_on;
		bit [6:0]  breathe_lo, breathe_hi;
		bit        pwm_fitted, lit_on_high;
		// pattern state
		mode_e     cur_mode;
		bit        running, lit;
		bit [31:0] since_start;
		bit [15:0] since_toggle, flashes_left;
		bit [6:0]  level;
		bit [15:0] sine_lut [SINE_STEPS];
		led_view_t led_states_due [$];
		int unsigned faults;

		function new();
			bit [63:0] one_q30, half_pi, n, a, num, f, x, x2, term, acc, u;
			bit        neg;
			one_q30 = 64'd1073741824;
			half_pi = 64'd1686629713;
			n       = 64'(SINE_STEPS);
			// quarter-wave fold, Q30 Taylor series to x^11
			for (int k = 0; k < SINE_STEPS; k++) begin
				a = 64'(4 * k);
				neg = (a > 2 * n);
				if (a <= n) begin
					num = a;
				end else if (a <= 2 * n) begin
					num = 2 * n - a;
				end else if (a <= 3 * n) begin
					num = a - 2 * n;
				end else begin
					num = 4 * n - a;
				end
				f    = (num << 30) / n;
				x    = (f * half_pi) >> 30;
				x2   = (x * x) >> 30;
				term = x;
				acc  = x;
				for (int i = 1; i <= 5; i++) begin
					term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
					if (i % 2 == 1) begin
						acc = acc - term;
					end else begin
						acc = acc + term;
					end
				end
				if (acc > one_q30) begin
					acc = one_q30;
				end
				u = neg ? one_q30 - acc : one_q30 + acc;
				sine_lut[k] = 16'((u * 64'd65535 + one_q30) >> 31);
			end
			slow_period    = 16'd1000;
			fast_period    = 16'd250;
			breathe_period = 16'd2000;
			flash_on       = 15'd100;
			breathe_lo     = 7'd10;
			breathe_hi     = 7'd100;
			pwm_fitted     = 1'b0;
			lit_on_high    = 1'b1;
			cur_mode       = MODE_OFF;
			running        = 1'b0;
			lit            = 1'b0;
			since_start    = '0;
			since_toggle   = '0;
			flashes_left   = '0;
			level          = 7'd100;
			faults         = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_SLOW_PERIOD:    slow_period    = val;
				REG_FAST_PERIOD:    fast_period    = val;
				REG_BREATHE_PERIOD: breathe_period = val;
				REG_FLASH_ON:       flash_on       = val[14:0];
				REG_BREATHE_MIN:    breathe_lo     = val[6:0];
				REG_BREATHE_MAX:    breathe_hi     = val[6:0];
				REG_PWM_PRESENT:    pwm_fitted     = val[0];
				REG_PIN_POLARITY:   lit_on_high    = val[0];
				default: ;
			endcase
		endfunction

		// apply one accepted word, queue the LED state it leaves behind
		function void take_word(logic [1:0] act, logic [2:0] m, logic [15:0] times,
				logic [7:0] req);
			bit [15:0] half;
			bit [31:0] flash_span;
			bit [63:0] period, phase, span, b;
			led_view_t view;
			case (act)
				ACT_TICK: if (running) begin
					since_start = since_start + 1;
					if (since_toggle != 16'hFFFF) begin
						since_toggle = since_toggle + 1;
					end
					case (cur_mode)
						MODE_SLOW, MODE_FAST: begin
							half = ((cur_mode == MODE_SLOW) ? slow_period : fast_period) >> 1;
							if (since_toggle >= half) begin
								lit = !lit;
								since_toggle = '0;
							end
						end
						MODE_BREATHE: begin
							period = (breathe_period != 0) ? 64'(breathe_period) : 64'd1;
							phase  = (64'(since_start) % period) * SINE_STEPS / period;
							if (phase >= SINE_STEPS) begin
								phase = SINE_STEPS - 1;
							end
							span = (breathe_hi >= breathe_lo) ? 64'(breathe_hi - breathe_lo) : 64'd0;
							b = 64'(breathe_lo) + (span * sine_lut[int'(phase)]) / 64'd65535;
							if (b > PCT_FULL) begin
								b = PCT_FULL;
							end
							level = b[6:0];
							if (!pwm_fitted) begin
								lit = (b > LIT_ABOVE_PCT);
							end
						end
						MODE_FLASH: if (flashes_left != 0) begin
							flash_span = {16'd0, flash_on, 1'b0};
							if (since_start < flash_on) begin
								lit = 1'b1;
							end else if (since_start < flash_span) begin
								lit = 1'b0;
							end else begin
								flashes_left = flashes_left - 1;
								since_start = '0;
								if (flashes_left == 0) begin
									running  = 1'b0;
									cur_mode = MODE_OFF;
									lit      = 1'b0;
								end
							end
						end
						default: ;
					endcase
				end
				ACT_SET_MODE: if (m <= MODE_FLASH) begin
					cur_mode     = mode_e'(m);
					since_start  = '0;
					since_toggle = '0;
					if (m == MODE_OFF) begin
						running = 1'b0;
						lit     = 1'b0;
					end else if (m == MODE_ON) begin
						running = 1'b0;
						lit     = 1'b1;
					end else begin
						running = 1'b1;
						if (m == MODE_FLASH) begin
							flashes_left = times;
						end
					end
				end
				ACT_SET_LEVEL: level = (req > PCT_FULL) ? 7'(PCT_FULL) : req[6:0];
				default: ;
			endcase
			view.pin    = lit ? lit_on_high : !lit_on_high;
			view.bright = level;
			view.pwm    = pwm_fitted ? 10'(level * PWM_PER_PCT) : 10'd0;
			view.mode   = cur_mode;
			view.run    = running;
			led_states_due.push_back(view);
		endfunction

		function void check_led(led_view_t got);
			led_view_t want;
			if (led_states_due.size() == 0) begin
				$error("result word with no prediction pending");
				faults++;
				return;
			end
			want = led_states_due.pop_front();
			if (got.pin !== want.pin) begin
				$error("pin_level: expected %0d, got %0d", want.pin, got.pin);
				faults++;
			end
			if (got.bright !== want.bright) begin
				$error("brightness_pct: expected %0d, got %0d", want.bright, got.bright);
				faults++;
			end
			if (got.pwm !== want.pwm) begin
				$error("pwm_compare: expected %0d, got %0d", want.pwm, got.pwm);
				faults++;
			end
			if (got.mode !== want.mode) begin
				$error("mode_now: expected %0d, got %0d", want.mode, got.mode);
				faults++;
			end
			if (got.run !== want.run) begin
				$error("pattern_running: expected %0d, got %0d", want.run, got.run);
				faults++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            action = '0;
	logic [2:0]            mode = '0;
	logic [15:0]           flash_times = '0;
	logic [7:0]            level_request = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  pin_level;
	logic [6:0]            brightness_pct;
	logic [9:0]            pwm_compare;
	logic [2:0]            mode_now;
	logic                  pattern_running;

	// set during one phase: neither side idles
	bit          calm_stretch = 1'b0;
	int unsigned cycle_count = 0;

	led_state_board led_board = new();

	led_pattern_generator_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.mode            (mode),
		.flash_times     (flash_times),
		.level_request   (level_request),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pin_level       (pin_level),
		.brightness_pct  (brightness_pct),
		.pwm_compare     (pwm_compare),
		.mode_now        (mode_now),
		.pattern_running (pattern_running)
	);

	always #4 clk = ~clk;

	// result side: random stalls, check every accepted word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			led_board.check_led({pin_level, brightness_pct, pwm_compare, mode_now,
				pattern_running});
		end
		out_ready <= calm_stretch || ($urandom_range(0, 99) >= 38);
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_led_pattern_generator_unit: errors");
			$finish;
		end
	end

	// Present one word, hold it until taken, then log it with the predictor.
	// valid is never dropped here; an idle gap drops it before the next word.
	task automatic send_word(input logic [1:0] act, input logic [2:0] m,
			input logic [15:0] times, input logic [7:0] req);
		while (!calm_stretch && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		mode          <= m;
		flash_times   <= times;
		level_request <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		led_board.take_word(act, m, times, req);
	endtask

	// mostly ticks so patterns get to run; some mode/level changes and noise
	task automatic random_word();
		int          roll;
		logic [1:0]  act;
		logic [2:0]  m;
		logic [15:0] times;
		roll  = $urandom_range(0, 99);
		m     = 3'($urandom_range(0, 7));
		times = 16'($urandom);
		if (roll < 76) begin
			act = ACT_TICK;
		end else if (roll < 88) begin
			act = ACT_SET_MODE;
			if ($urandom_range(0, 9) < 2) begin
				m = 3'($urandom_range(MODE_OFF, MODE_ON));
			end else begin
				m = 3'($urandom_range(MODE_SLOW, MODE_FLASH));
			end
			// short flash runs so flash mode can finish on its own
			if ($urandom_range(0, 3) != 0) begin
				times = 16'($urandom_range(0, 4));
			end
		end else if (roll < 94) begin
			act = ACT_SET_LEVEL;
		end else if (roll < 97) begin
			act = ACT_UNKNOWN;
		end else begin
			act = ACT_SET_MODE;
			m = 3'($urandom_range(MODE_RSVD_6, MODE_RSVD_7));
		end
		send_word(act, m, times, 8'($urandom));
	endtask

	// hold off input until every predicted word is out, then let the unit settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (led_board.led_states_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; we stays high across back-to-back writes
	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		led_board.write_reg(idx, val);
		@(posedge clk);
	endtask

	// write all eight registers; only called with the unit idle
	task automatic load_settings(input logic [15:0] slow, input logic [15:0] fast,
			input logic [15:0] breathe, input logic [15:0] on_ms,
			input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] pwm, input logic [15:0] polarity);
		reg_write(REG_SLOW_PERIOD, slow);
		reg_write(REG_FAST_PERIOD, fast);
		reg_write(REG_BREATHE_PERIOD, breathe);
		reg_write(REG_FLASH_ON, on_ms);
		reg_write(REG_BREATHE_MIN, lo);
		reg_write(REG_BREATHE_MAX, hi);
		reg_write(REG_PWM_PRESENT, pwm);
		reg_write(REG_PIN_POLARITY, polarity);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: idle tick, junk codes, level clamp, mode changes
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_UNKNOWN, MODE_RSVD_7, 16'hFFFF, 8'hFF);
		send_word(ACT_SET_LEVEL, MODE_OFF, 16'h0000, 8'hFF);
		send_word(ACT_SET_LEVEL, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_SET_LEVEL, MODE_OFF, 16'h0000, 8'd101);
		send_word(ACT_SET_LEVEL, MODE_OFF, 16'h0000, 8'd100);
		send_word(ACT_SET_MODE, MODE_RSVD_6, 16'h0001, 8'h00);
		send_word(ACT_SET_MODE, MODE_RSVD_7, 16'h0001, 8'h00);
		send_word(ACT_SET_MODE, MODE_ON, 16'h0000, 8'h00);
		send_word(ACT_SET_MODE, MODE_OFF, 16'h0000, 8'h00);
		// flash with zero count keeps running and does nothing
		send_word(ACT_SET_MODE, MODE_FLASH, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_SET_MODE, MODE_SLOW, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		drain_results();

		// degenerate settings: blink toggles every tick, breathe period zero,
		// zero flash time, breathe max beyond 100 so brightness saturates
		load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd90, 16'd127, 16'd1, 16'd0);
		send_word(ACT_SET_MODE, MODE_SLOW, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_SET_MODE, MODE_FAST, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_SET_MODE, MODE_BREATHE, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_SET_MODE, MODE_FLASH, 16'h0002, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_TICK, MODE_OFF, 16'h0000, 8'h00);
		send_word(ACT_SET_MODE, MODE_FLASH, 16'hFFFF, 8'h00);
		drain_results();

		// random phases: small periods so patterns cycle, plus the extremes
		for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
			case (phase_no)
				0: load_settings(16'd20, 16'd6, 16'd64, 16'd3, 16'd10, 16'd100,
					16'd0, 16'd1);
				1: load_settings(16'd65535, 16'd65535, 16'd65535, 16'd32767, 16'd0,
					16'd100, 16'd1, 16'd0);
				2: load_settings(16'd2, 16'd2, 16'd1, 16'd1, 16'd100, 16'd0,
					16'd0, 16'd1);
				default: load_settings(16'($urandom_range(2, 40)),
					16'($urandom_range(2, 16)), 16'($urandom_range(1, 400)),
					16'($urandom_range(1, 6)), 16'($urandom_range(0, 100)),
					16'($urandom_range(0, 100)), 16'($urandom_range(0, 1)),
					16'($urandom_range(0, 1)));
			endcase
			calm_stretch = (phase_no == 2);
			repeat (WORDS_PER_PHASE) random_word();
			drain_results();
			calm_stretch = 1'b0;
		end

		if (led_board.faults == 0 && led_board.led_states_due.size() == 0) begin
			$display("tb_led_pattern_generator_unit: clean");
		end else begin
			$display("tb_led_pattern_generator_unit: errors");
		end
		$finish;
	end

endmodule

@@ led_pattern_generator_unit.f @@
rtl/lpg_pkg.sv
rtl/lpg_div.sv
rtl/lpg_datapath.sv
rtl/lpg_ctrl.sv
rtl/led_pattern_generator_unit.sv
dv/tb_led_pattern_generator_unit.sv
